### src/qpht_pkg.sv
package qpht_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
    localparam bit POW2_SLOTS  = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;

    localparam int OP_W    = 2;
    localparam int KEY_W   = 31;
    localparam int REC_W   = 32;
    localparam int IDX_W   = 4;
    localparam int STAT_W  = 2;
    localparam int OSLOT_W = 4;
    localparam int RCNT_W  = 5;
    localparam int ENTRY_W = KEY_W + REC_W;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HOME,
        S_PROBE,
        S_DEL_SCAN,
        S_DEL_LAST,
        S_DEL_FIN,
        S_READ,
        S_READ_DATA,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic start;
        logic step;
    } t_probe_ctl;

    typedef struct packed {
        logic              home_ok;
        logic [SLOT_W-1:0] pos;
        logic              last;
    } t_probe_sts;

endpackage

### src/qpht_ram.sv
module qpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/qpht_probe.sv
module qpht_probe
    import qpht_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_probe_ctl       i_ctl,
    input  logic [KEY_W-1:0] i_key,
    output t_probe_sts       o_sts
);

    localparam logic [SLOT_W:0]   N_EXT    = (SLOT_W + 1)'(TABLE_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_CNT = SLOT_W'(TABLE_SLOTS - 1);
    localparam int                NB_W     = $clog2(KEY_W + 1);

    logic [SLOT_W-1:0] r_pos, n_pos;
    logic [SLOT_W-1:0] r_inc, n_inc;
    logic [SLOT_W-1:0] r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic [KEY_W-1:0]  r_bits, n_bits;
    logic [NB_W-1:0]   r_nbits, n_nbits;
    logic [SLOT_W:0]   rem_sum;
    logic [SLOT_W:0]   pos_sum;
    logic [SLOT_W:0]   inc_sum;
    logic [SLOT_W-1:0] rem_red;

    always_comb begin
        // key mod size, one key bit per cycle
        rem_sum = {r_pos, r_bits[KEY_W-1]};
        rem_red = (rem_sum >= N_EXT) ? SLOT_W'(rem_sum - N_EXT) : SLOT_W'(rem_sum);
        // (key + i*i) advances by 2i+1 each probe
        pos_sum = {1'b0, r_pos} + {1'b0, r_inc};
        inc_sum = {1'b0, r_inc} + (SLOT_W + 1)'(2);

        n_pos   = r_pos;
        n_inc   = r_inc;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_bits  = r_bits;
        n_nbits = r_nbits;

        if (i_ctl.start) begin
            n_inc = SLOT_W'(1);
            n_cnt = '0;
            if (POW2_SLOTS) begin
                n_pos  = i_key[SLOT_W-1:0];
                n_busy = 1'b0;
            end else begin
                n_pos   = '0;
                n_bits  = i_key;
                n_nbits = NB_W'(KEY_W);
                n_busy  = 1'b1;
            end
        end else if (r_busy) begin
            n_pos   = rem_red;
            n_bits  = {r_bits[KEY_W-2:0], 1'b0};
            n_nbits = r_nbits - NB_W'(1);
            if (r_nbits == NB_W'(1)) begin
                n_busy = 1'b0;
            end
        end else if (i_ctl.step) begin
            n_pos = (pos_sum >= N_EXT) ? SLOT_W'(pos_sum - N_EXT) : SLOT_W'(pos_sum);
            n_inc = (inc_sum >= N_EXT) ? SLOT_W'(inc_sum - N_EXT) : SLOT_W'(inc_sum);
            n_cnt = r_cnt + SLOT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_pos   <= n_pos;
        r_inc   <= n_inc;
        r_cnt   <= n_cnt;
        r_bits  <= n_bits;
        r_nbits <= n_nbits;
    end

    assign o_sts.home_ok = !r_busy;
    assign o_sts.pos     = r_pos;
    assign o_sts.last    = (r_cnt == LAST_CNT);

endmodule

### src/quadratic_probe_hash_table.sv
// channel  direction  handshake                 payload
// in       input      i_in_valid / o_in_ready   opcode, key, record, slot_index
// out      output     o_out_valid / i_out_ready status, slot, entry_*, removed_count
//
// insert: probes up to TABLE_SLOTS slots, home slot first, set by the probe sequencer;
//   a table size that is not a power of two first reduces the key one bit at a time
// delete: scans every slot, one key read per cycle from the entry ram
// read: one ram read; one item is in work at a time
// reset clears the used flags at once, so the table is empty on the first cycle
// a result waiting on the out side does not stop the next input transfer
module quadratic_probe_hash_table
    import qpht_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [OP_W-1:0]    i_opcode,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [REC_W-1:0]   i_record,
    input  logic [IDX_W-1:0]   i_slot_index,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [STAT_W-1:0]  o_status,
    output logic [OSLOT_W-1:0] o_slot,
    output logic               o_entry_valid,
    output logic [KEY_W-1:0]   o_entry_key,
    output logic [REC_W-1:0]   o_entry_record,
    output logic [RCNT_W-1:0]  o_removed_count
);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
    localparam int                CMP_W     = (IDX_W > SLOT_W + 1) ? IDX_W : SLOT_W + 1;

    t_state                 r_state, n_state;
    logic [TABLE_SLOTS-1:0] r_used, n_used;
    logic [SLOT_W-1:0]      r_scan, n_scan;
    logic                   r_chk_v, n_chk_v;
    logic [SLOT_W-1:0]      r_chk_addr, n_chk_addr;
    logic [CNT_W-1:0]       r_cnt, n_cnt;

    logic [KEY_W-1:0]       r_key;
    logic [REC_W-1:0]       r_rec;
    logic [IDX_W-1:0]       r_idx;

    t_status                r_p_status, n_p_status;
    logic [OSLOT_W-1:0]     r_p_slot, n_p_slot;
    logic                   r_p_ev, n_p_ev;
    logic [KEY_W-1:0]       r_p_key, n_p_key;
    logic [REC_W-1:0]       r_p_rec, n_p_rec;
    logic [RCNT_W-1:0]      r_p_cnt, n_p_cnt;

    logic                   r_o_valid;
    t_status                r_o_status;
    logic [OSLOT_W-1:0]     r_o_slot;
    logic                   r_o_ev;
    logic [KEY_W-1:0]       r_o_key;
    logic [REC_W-1:0]       r_o_rec;
    logic [RCNT_W-1:0]      r_o_cnt;

    t_probe_ctl             probe_ctl;
    t_probe_sts             probe_sts;
    logic                   mem_we;
    logic [SLOT_W-1:0]      mem_raddr;
    logic [ENTRY_W-1:0]     mem_rdata;
    logic [KEY_W-1:0]       rd_key;
    logic [REC_W-1:0]       rd_rec;
    logic [SLOT_W-1:0]      idx_slot;
    logic                   idx_in_range;
    logic                   in_xfer;
    logic                   out_free;
    logic                   load_out;

    assign in_xfer      = i_in_valid && o_in_ready;
    assign out_free     = !r_o_valid || i_out_ready;
    assign rd_key       = mem_rdata[ENTRY_W-1:REC_W];
    assign rd_rec       = mem_rdata[REC_W-1:0];
    assign idx_slot     = SLOT_W'(r_idx);
    assign idx_in_range = CMP_W'(r_idx) < CMP_W'(TABLE_SLOTS);
    assign mem_raddr    = (r_state == S_DEL_SCAN) ? r_scan : idx_slot;

    qpht_probe u_probe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (probe_ctl),
        .i_key   (i_key),
        .o_sts   (probe_sts)
    );

    qpht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (probe_sts.pos),
        .i_wdata ({r_key, r_rec}),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_used     = r_used;
        n_scan     = r_scan;
        n_chk_v    = 1'b0;
        n_chk_addr = r_scan;
        n_cnt      = r_cnt;
        n_p_status = r_p_status;
        n_p_slot   = r_p_slot;
        n_p_ev     = r_p_ev;
        n_p_key    = r_p_key;
        n_p_rec    = r_p_rec;
        n_p_cnt    = r_p_cnt;
        probe_ctl  = '0;
        mem_we     = 1'b0;
        load_out   = 1'b0;

        // delete compare, in the cycle after the scan address
        if (r_chk_v && r_used[r_chk_addr] && (rd_key == r_key)) begin
            n_used[r_chk_addr] = 1'b0;
            n_cnt              = r_cnt + CNT_W'(1);
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    case (t_op'(i_opcode))
                        OP_INSERT: begin
                            probe_ctl.start = 1'b1;
                            n_state         = S_HOME;
                        end
                        OP_DELETE: begin
                            n_scan  = '0;
                            n_cnt   = '0;
                            n_state = S_DEL_SCAN;
                        end
                        OP_READ: begin
                            n_state = S_READ;
                        end
                        default: begin
                            n_p_status = ST_DONE;
                            n_p_slot   = '0;
                            n_p_ev     = 1'b0;
                            n_p_key    = '0;
                            n_p_rec    = '0;
                            n_p_cnt    = '0;
                            n_state    = S_EMIT;
                        end
                    endcase
                end
            end
            S_HOME: begin
                if (probe_sts.home_ok) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                n_p_ev  = 1'b0;
                n_p_key = '0;
                n_p_rec = '0;
                n_p_cnt = '0;
                if (!r_used[probe_sts.pos]) begin
                    mem_we                 = 1'b1;
                    n_used[probe_sts.pos]  = 1'b1;
                    n_p_status             = ST_DONE;
                    n_p_slot               = OSLOT_W'(probe_sts.pos);
                    n_state                = S_EMIT;
                end else if (probe_sts.last) begin
                    n_p_status = ST_OVERFLOW;
                    n_p_slot   = '0;
                    n_state    = S_EMIT;
                end else begin
                    probe_ctl.step = 1'b1;
                end
            end
            S_DEL_SCAN: begin
                n_chk_v    = 1'b1;
                n_chk_addr = r_scan;
                if (r_scan == LAST_SLOT) begin
                    n_state = S_DEL_LAST;
                end else begin
                    n_scan = r_scan + SLOT_W'(1);
                end
            end
            S_DEL_LAST: begin
                n_state = S_DEL_FIN;
            end
            S_DEL_FIN: begin
                n_p_status = (r_cnt == '0) ? ST_NOT_FOUND : ST_DONE;
                n_p_slot   = '0;
                n_p_ev     = 1'b0;
                n_p_key    = '0;
                n_p_rec    = '0;
                n_p_cnt    = RCNT_W'(r_cnt);
                n_state    = S_EMIT;
            end
            S_READ: begin
                n_state = S_READ_DATA;
            end
            S_READ_DATA: begin
                n_p_status = ST_DONE;
                n_p_slot   = OSLOT_W'(r_idx);
                n_p_ev     = idx_in_range && r_used[idx_slot];
                n_p_key    = n_p_ev ? rd_key : '0;
                n_p_rec    = n_p_ev ? rd_rec : '0;
                n_p_cnt    = '0;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_chk_v   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_chk_v <= n_chk_v;
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan     <= n_scan;
        r_chk_addr <= n_chk_addr;
        r_cnt      <= n_cnt;
        r_p_status <= n_p_status;
        r_p_slot   <= n_p_slot;
        r_p_ev     <= n_p_ev;
        r_p_key    <= n_p_key;
        r_p_rec    <= n_p_rec;
        r_p_cnt    <= n_p_cnt;
        if (in_xfer) begin
            r_key <= i_key;
            r_rec <= i_record;
            r_idx <= i_slot_index;
        end
        if (load_out) begin
            r_o_status <= r_p_status;
            r_o_slot   <= r_p_slot;
            r_o_ev     <= r_p_ev;
            r_o_key    <= r_p_key;
            r_o_rec    <= r_p_rec;
            r_o_cnt    <= r_p_cnt;
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_o_valid;
    assign o_status        = r_o_status;
    assign o_slot          = r_o_slot;
    assign o_entry_valid   = r_o_ev;
    assign o_entry_key     = r_o_key;
    assign o_entry_record  = r_o_rec;
    assign o_removed_count = r_o_cnt;

    a_busy_after_transfer: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_in_ready
    ) else $error("input still ready right after a transfer");

    a_write_marks_used: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> r_used[$past(probe_sts.pos)]
    ) else $error("inserted slot not marked used");

    a_not_found_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_NOT_FOUND)) |-> (o_removed_count == '0)
    ) else $error("not-found result with nonzero removed count");

    a_read_empty_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_entry_valid) |-> (o_entry_key == '0 && o_entry_record == '0)
    ) else $error("empty entry result carries data");

endmodule

### tb/sv/testbench.sv
module testbench;
    import qpht_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;
    localparam int POOL_SIZE    = 12;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [OSLOT_W-1:0] slot;
        logic               entry_valid;
        logic [KEY_W-1:0]   entry_key;
        logic [REC_W-1:0]   entry_record;
        logic [RCNT_W-1:0]  removed_count;
    } t_hash_result;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [OP_W-1:0]    opcode;
    logic [KEY_W-1:0]   key;
    logic [REC_W-1:0]   record;
    logic [IDX_W-1:0]   slot_index;
    logic               out_valid;
    logic               out_ready;
    logic [STAT_W-1:0]  status;
    logic [OSLOT_W-1:0] slot;
    logic               entry_valid;
    logic [KEY_W-1:0]   entry_key;
    logic [REC_W-1:0]   entry_record;
    logic [RCNT_W-1:0]  removed_count;

    // shadow copy of the table
    bit                 tbl_used [TABLE_SLOTS];
    logic [KEY_W-1:0]   tbl_key  [TABLE_SLOTS];
    logic [REC_W-1:0]   tbl_rec  [TABLE_SLOTS];

    t_hash_result       pending_results[$];
    logic [KEY_W-1:0]   key_pool[POOL_SIZE];

    int  mismatch_count = 0;
    int  rx_gap         = 0;
    int  rx_hold        = 0;
    bit  hold_req       = 1'b0;
    bit  burst_mode     = 1'b0;
    int  idle_cycles    = 0;

    quadratic_probe_hash_table i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_opcode        (opcode),
        .i_key           (key),
        .i_record        (record),
        .i_slot_index    (slot_index),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_status        (status),
        .o_slot          (slot),
        .o_entry_valid   (entry_valid),
        .o_entry_key     (entry_key),
        .o_entry_record  (entry_record),
        .o_removed_count (removed_count)
    );

    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // table update and expected result for one operation
    function automatic t_hash_result apply_op(t_op op, logic [KEY_W-1:0] k,
                                              logic [REC_W-1:0] r, logic [IDX_W-1:0] idx);
        t_hash_result res;
        int           pos;
        int           cnt;
        bit           placed;
        res    = '0;
        cnt    = 0;
        placed = 1'b0;
        res.status = ST_DONE;
        case (op)
            OP_INSERT: begin
                for (int i = 0; i < TABLE_SLOTS && !placed; i++) begin
                    pos = int'((longint'(k) + longint'(i) * longint'(i)) % TABLE_SLOTS);
                    if (!tbl_used[pos]) begin
                        tbl_used[pos] = 1'b1;
                        tbl_key[pos]  = k;
                        tbl_rec[pos]  = r;
                        res.slot      = pos[OSLOT_W-1:0];
                        placed        = 1'b1;
                    end
                end
                if (!placed)
                    res.status = ST_OVERFLOW;
            end
            OP_DELETE: begin
                for (int s = 0; s < TABLE_SLOTS; s++) begin
                    if (tbl_used[s] && tbl_key[s] == k) begin
                        tbl_used[s] = 1'b0;
                        tbl_key[s]  = '0;
                        tbl_rec[s]  = '0;
                        cnt++;
                    end
                end
                res.removed_count = cnt[RCNT_W-1:0];
                if (cnt == 0)
                    res.status = ST_NOT_FOUND;
            end
            OP_READ: begin
                res.slot = idx;
                if (int'(idx) < TABLE_SLOTS && tbl_used[idx]) begin
                    res.entry_valid  = 1'b1;
                    res.entry_key    = tbl_key[idx];
                    res.entry_record = tbl_rec[idx];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // one input transfer; entered and left at a falling edge
    task automatic send_item(t_op op, logic [KEY_W-1:0] k, logic [REC_W-1:0] r,
                             logic [IDX_W-1:0] idx);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        key        <= k;
        record     <= r;
        slot_index <= idx;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(apply_op(op, k, r, idx));
        @(negedge clk);
    endtask

    task automatic wait_until_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
    endtask

    task automatic send_random_item();
        int               pick;
        t_op              op;
        logic [KEY_W-1:0] k;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            op = OP_INSERT;
        else if (pick < 65)
            op = OP_DELETE;
        else if (pick < 95)
            op = OP_READ;
        else
            op = OP_NOP;
        // mostly pooled keys so inserts collide and deletes find matches
        if ($urandom_range(0, 4) == 0)
            k = KEY_W'($urandom);
        else
            k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        send_item(op, k, $urandom, IDX_W'($urandom));
    endtask

    task automatic test_directed();
        send_item(OP_READ,   '0, '0, 4'd0);
        send_item(OP_READ,   '1, '1, 4'd15);
        send_item(OP_INSERT, '0, '0, 4'd0);
        send_item(OP_INSERT, '1, '1, 4'd0);
        // same home slot: probe walks 0, 1, 4, 9 and then runs out
        send_item(OP_INSERT, 31'd16, 32'h1111_1111, 4'd0);
        send_item(OP_INSERT, 31'd32, 32'h2222_2222, 4'd0);
        send_item(OP_INSERT, 31'd48, 32'h3333_3333, 4'd0);
        send_item(OP_INSERT, 31'd64, 32'h4444_4444, 4'd0);
        // duplicate key lands in the next probe slot
        send_item(OP_INSERT, 31'd5, 32'hA5A5_A5A5, 4'd0);
        send_item(OP_INSERT, 31'd5, 32'h5A5A_5A5A, 4'd0);
        send_item(OP_READ,   '0, '0, 4'd1);
        send_item(OP_READ,   '0, '0, 4'd4);
        send_item(OP_READ,   '0, '0, 4'd9);
        send_item(OP_READ,   '0, '0, 4'd6);
        send_item(OP_READ,   '0, '0, 4'd15);
        send_item(OP_DELETE, 31'd5, '0, 4'd0);
        send_item(OP_DELETE, 31'd5, '0, 4'd0);
        send_item(OP_DELETE, '0, '0, 4'd0);
        send_item(OP_DELETE, '1, '0, 4'd0);
        send_item(OP_READ,   '0, '0, 4'd15);
        send_item(OP_NOP,    '1, '1, 4'd15);
        wait_until_drained();
    endtask

    task automatic test_full_table();
        for (int i = 0; i < TABLE_SLOTS; i++)
            send_item(OP_INSERT, KEY_W'(i), $urandom, '0);
        send_item(OP_INSERT, KEY_W'($urandom), $urandom, '0);
        for (int i = 0; i < TABLE_SLOTS; i++)
            send_item(OP_READ, '0, '0, IDX_W'(i));
        for (int i = 0; i < TABLE_SLOTS; i++)
            send_item(OP_DELETE, KEY_W'(i), '0, '0);
    endtask

    task automatic test_random_traffic(int n);
        for (int i = 0; i < n; i++)
            send_random_item();
    endtask

    task automatic test_back_to_back(int n);
        burst_mode = 1'b1;
        test_random_traffic(n);
        burst_mode = 1'b0;
    endtask

    task automatic test_output_stall(int n);
        hold_req = 1'b1;
        test_random_traffic(n);
    endtask

    task automatic test_sender_pause(int rounds);
        for (int i = 0; i < rounds; i++) begin
            test_random_traffic($urandom_range(3, 12));
            wait_until_drained();
        end
    endtask

    // receiver: random gaps after each transfer, plus a long hold-off on request
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_hold > 0) begin
                out_ready <= 1'b0;
                rx_hold--;
            end else if (rx_gap > 0) begin
                out_ready <= 1'b0;
                rx_gap--;
            end else begin
                out_ready <= rst_n;
            end
        end
    end

    // result checker
    always @(posedge clk) begin
        t_hash_result exp_res;
        t_hash_result got;
        if (hold_req) begin
            rx_hold  = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (rst_n && out_valid && out_ready) begin
            got = '{status, slot, entry_valid, entry_key, entry_record, removed_count};
            rx_gap = burst_mode ? 0 : $urandom_range(0, 4);
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected: status %0d slot %0d valid %0b key %h rec %h cnt %0d",
                             got.status, got.slot, got.entry_valid, got.entry_key,
                             got.entry_record, got.removed_count);
            end else begin
                exp_res = pending_results.pop_front();
                if (got.status !== exp_res.status || got.slot !== exp_res.slot ||
                    got.entry_valid !== exp_res.entry_valid ||
                    got.entry_key !== exp_res.entry_key ||
                    got.entry_record !== exp_res.entry_record ||
                    got.removed_count !== exp_res.removed_count) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("expected: status %0d slot %0d valid %0b key %h rec %h cnt %0d",
                                 exp_res.status, exp_res.slot, exp_res.entry_valid,
                                 exp_res.entry_key, exp_res.entry_record, exp_res.removed_count);
                        $display("actual:   status %0d slot %0d valid %0b key %h rec %h cnt %0d",
                                 got.status, got.slot, got.entry_valid, got.entry_key,
                                 got.entry_record, got.removed_count);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        opcode     = '0;
        key        = '0;
        record     = '0;
        slot_index = '0;
        for (int s = 0; s < TABLE_SLOTS; s++) begin
            tbl_used[s] = 1'b0;
            tbl_key[s]  = '0;
            tbl_rec[s]  = '0;
        end
        // pool keys share a few home slots but carry random upper bits
        for (int j = 0; j < POOL_SIZE; j++)
            key_pool[j] = {KEY_W'($urandom) & ~KEY_W'(15)} | KEY_W'($urandom_range(0, 5));
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_full_table();
        test_random_traffic(400);
        test_output_stall(40);
        test_back_to_back(120);
        test_sender_pause(8);
        test_random_traffic(300);

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
